// ===== src/alarm_clock_controller_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Alarm clock controller defines
// Assertion macros used by the verification checker.
// ---------------------------------------------------------------------------
`ifndef ALARM_CLOCK_CONTROLLER_UNIT_DEFINES_SVH
`define ALARM_CLOCK_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define ACC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("acc assertion failed");

// Next-cycle implication, checked through reset as well
`define ACC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("acc assertion failed");

`endif

// ===== src/acc_pkg.sv =====
// ---------------------------------------------------------------------------
// Alarm clock controller package
// Shared widths, codes, reset values, segment table and helper functions.
// ---------------------------------------------------------------------------
package acc_pkg;

    localparam int KEY_W     = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int SEG_W     = 8;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;

    // Key codes; anything above KEY_DOWN counts as another key
    localparam logic [KEY_W-1:0] KEY_NONE  = 3'd0;
    localparam logic [KEY_W-1:0] KEY_SETUP = 3'd1;
    localparam logic [KEY_W-1:0] KEY_ALARM = 3'd2;
    localparam logic [KEY_W-1:0] KEY_UP    = 3'd3;
    localparam logic [KEY_W-1:0] KEY_DOWN  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INACTIVITY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK         = 3'd4;

    localparam logic [CFG_W-1:0] RST_TICKS_PER_SEC = 16'd1000;
    localparam logic [CFG_W-1:0] RST_INACTIVITY    = 16'd30000;
    localparam logic [CFG_W-1:0] RST_RING          = 16'd5000;
    localparam logic [CFG_W-1:0] RST_BEEP          = 16'd300;
    localparam logic [CFG_W-1:0] RST_BLINK         = 16'd500;

    localparam logic [HOUR_W-1:0] RST_ALARM_HOUR = 5'd7;
    localparam logic [MIN_W-1:0]  RST_ALARM_MIN  = 6'd0;

    localparam int RING_PERIOD  = 1000;
    localparam int RING_ON_PART = 500;
    localparam int RING_PH_W    = $clog2(RING_PERIOD);

    localparam logic [MIN_W-1:0] HOUR_MAX   = 6'd23;
    localparam logic [MIN_W-1:0] MINUTE_MAX = 6'd59;

    localparam logic [SEG_W-1:0] COLON_BIT = 8'h80;

    // Segments gfedcba for digits 0..9
    localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
        8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic               alarm_view;
        logic               blank_hour;
        logic               blank_minute;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
    } t_disp_req;

    typedef struct packed {
        logic [SEG_W-1:0] hour_tens;
        logic [SEG_W-1:0] hour_units;
        logic [SEG_W-1:0] minute_tens;
        logic [SEG_W-1:0] minute_units;
    } t_disp_out;

    function automatic logic [CFG_W-1:0] sat_inc(input logic [CFG_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [MIN_W-1:0] wrap_up(input logic [MIN_W-1:0] v,
                                                 input logic [MIN_W-1:0] max);
        return (v >= max) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [MIN_W-1:0] wrap_down(input logic [MIN_W-1:0] v,
                                                   input logic [MIN_W-1:0] max);
        return (v == '0) ? max : v - 1'b1;
    endfunction

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        return (d <= 4'd9) ? SEG_TABLE[d] : '0;
    endfunction

    // Tens digit by compare chain, values up to 63
    function automatic logic [3:0] tens_of(input logic [MIN_W-1:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [MIN_W-1:0] v);
        logic [MIN_W-1:0] base;
        base = {2'b00, tens_of(v)} * 6'd10;
        return 4'(v - base);
    endfunction

endpackage

// ===== src/acc_in_if.sv =====
// ---------------------------------------------------------------------------
// Tick input channel
// Valid/ready channel carrying one key code per tick transaction.
// ---------------------------------------------------------------------------
interface acc_in_if;
    logic                      valid;
    logic                      ready;
    logic [acc_pkg::KEY_W-1:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

// ===== src/acc_out_if.sv =====
// ---------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying display, buzzer, LED and save fields.
// ---------------------------------------------------------------------------
interface acc_out_if;
    logic                       valid;
    logic                       ready;
    logic [acc_pkg::SEG_W-1:0]  digit_hour_tens;
    logic [acc_pkg::SEG_W-1:0]  digit_hour_units;
    logic [acc_pkg::SEG_W-1:0]  digit_minute_tens;
    logic [acc_pkg::SEG_W-1:0]  digit_minute_units;
    logic                       buzzer_on;
    logic                       alarm_mode_led;
    logic                       save_strobe;
    logic [acc_pkg::HOUR_W-1:0] save_hour;
    logic [acc_pkg::MIN_W-1:0]  save_minute;

    modport source (output valid, output digit_hour_tens, output digit_hour_units,
                    output digit_minute_tens, output digit_minute_units,
                    output buzzer_on, output alarm_mode_led, output save_strobe,
                    output save_hour, output save_minute, input ready);
    modport sink   (input valid, input digit_hour_tens, input digit_hour_units,
                    input digit_minute_tens, input digit_minute_units,
                    input buzzer_on, input alarm_mode_led, input save_strobe,
                    input save_hour, input save_minute, output ready);
endinterface

// ===== src/acc_display.sv =====
// ---------------------------------------------------------------------------
// Seven-segment display encoder
// Splits hour and minute into digits, adds the colon and blink blanking.
// ---------------------------------------------------------------------------
module acc_display (
    input  acc_pkg::t_disp_req i_req,
    output acc_pkg::t_disp_out o_disp
);

    logic [acc_pkg::MIN_W-1:0] hour_ext;
    logic [acc_pkg::SEG_W-1:0] d0, d1, d2, d3;

    assign hour_ext = {1'b0, i_req.hour};

    always_comb begin
        d0 = acc_pkg::seg_of(acc_pkg::tens_of(hour_ext));
        d1 = acc_pkg::seg_of(acc_pkg::units_of(hour_ext));
        d2 = acc_pkg::seg_of(acc_pkg::tens_of(i_req.minute));
        d3 = acc_pkg::seg_of(acc_pkg::units_of(i_req.minute));
        // colon only on the time of day
        if (!i_req.alarm_view) begin
            d1 = d1 | acc_pkg::COLON_BIT;
        end
        if (i_req.blank_hour) begin
            d0 = '0;
            d1 = d1 & acc_pkg::COLON_BIT;
        end
        if (i_req.blank_minute) begin
            d2 = '0;
            d3 = '0;
        end
    end

    assign o_disp.hour_tens    = d0;
    assign o_disp.hour_units   = d1;
    assign o_disp.minute_tens  = d2;
    assign o_disp.minute_units = d3;

endmodule

// ===== src/alarm_clock_controller_unit.sv =====
// A tick transaction is captured in the input register; its result is then registered in the result register.
// Throughput: one tick per cycle while the result channel is not stalled; the input register and the result register
// both advance in the same cycle, so the block can take a new tick while the last result is still held.
// The clock state updates in one pass of logic from the input register.
// Reset (synchronous, active low) clears the valid flags and the clock state, loads the alarm and its
// saved copy with 07:00 and restores the register defaults.
// ---------------------------------------------------------------------------
// Alarm clock controller
// Time keeping, adjust modes, alarm ring, key beep and display per tick.
// ---------------------------------------------------------------------------
module alarm_clock_controller_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [acc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [acc_pkg::CFG_W-1:0]     i_cfg_data,
    acc_in_if.sink                        i_in,
    acc_out_if.source                     o_out
);

    typedef enum logic [2:0] {
        MODE_CLOCK        = 3'd0,
        MODE_HOUR         = 3'd1,
        MODE_MINUTE       = 3'd2,
        MODE_ALARM_HOUR   = 3'd3,
        MODE_ALARM_MINUTE = 3'd4
    } t_mode;

    // configuration
    logic [acc_pkg::CFG_W-1:0] r_cfg_tps, r_cfg_idle, r_cfg_ring, r_cfg_beep, r_cfg_blink;

    // input stage
    logic                      r_a_valid;
    logic [acc_pkg::KEY_W-1:0] r_a_key;
    logic                      a_fire;

    // clock state
    t_mode                       r_mode, n_mode;
    logic [acc_pkg::HOUR_W-1:0]  r_hours, n_hours, r_alarm_hour, n_alarm_hour;
    logic [acc_pkg::HOUR_W-1:0]  r_st_hour, n_st_hour;
    logic [acc_pkg::MIN_W-1:0]   r_minutes, n_minutes, r_seconds, n_seconds;
    logic [acc_pkg::MIN_W-1:0]   r_alarm_min, n_alarm_min, r_st_min, n_st_min;
    logic [acc_pkg::CFG_W-1:0]   r_subsec, n_subsec, r_ring_count, n_ring_count;
    logic [acc_pkg::CFG_W-1:0]   r_beep_count, n_beep_count, r_idle_count, n_idle_count;
    logic [acc_pkg::CFG_W-1:0]   r_blink_count, n_blink_count;
    logic [acc_pkg::RING_PH_W-1:0] r_ring_phase, n_ring_phase;
    logic r_alarm_changed, n_alarm_changed, r_ringing, n_ringing;
    logic r_blink_phase, n_blink_phase, r_buzzer, n_buzzer;
    logic saved;
    logic led;

    acc_pkg::t_disp_req disp_req;
    acc_pkg::t_disp_out disp;

    // result register
    logic                       r_out_valid;
    acc_pkg::t_disp_out         r_out_disp;
    logic                       r_out_buzzer, r_out_led, r_out_save;
    logic [acc_pkg::HOUR_W-1:0] r_out_save_hour;
    logic [acc_pkg::MIN_W-1:0]  r_out_save_min;

    assign a_fire     = r_a_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_a_valid || a_fire;

    // Per-tick update, in the order keys, time, alarm, beep, display,
    // timeout, blink.
    always_comb begin
        logic time_carry_m, time_carry_h;
        time_carry_m    = 1'b0;
        time_carry_h    = 1'b0;
        n_mode          = r_mode;
        n_hours         = r_hours;
        n_minutes       = r_minutes;
        n_seconds       = r_seconds;
        n_subsec        = r_subsec;
        n_alarm_hour    = r_alarm_hour;
        n_alarm_min     = r_alarm_min;
        n_st_hour       = r_st_hour;
        n_st_min        = r_st_min;
        n_alarm_changed = r_alarm_changed;
        n_ringing       = r_ringing;
        n_ring_count    = r_ring_count;
        n_ring_phase    = r_ring_phase;
        n_beep_count    = r_beep_count;
        n_idle_count    = r_idle_count;
        n_blink_count   = r_blink_count;
        n_blink_phase   = r_blink_phase;
        n_buzzer        = r_buzzer;
        saved           = 1'b0;

        // keys
        if (r_a_key != acc_pkg::KEY_NONE) begin
            if (r_ringing) begin
                // a key only silences the ring
                n_ringing = 1'b0;
                if (r_beep_count == '0) begin
                    n_buzzer = 1'b0;
                end
            end else begin
                n_buzzer      = 1'b1;
                n_beep_count  = r_cfg_beep;
                n_idle_count  = '0;
                n_blink_phase = 1'b0;
                n_blink_count = '0;
                case (r_a_key)
                    acc_pkg::KEY_SETUP: begin
                        if (r_mode == MODE_CLOCK)     n_mode = MODE_HOUR;
                        else if (r_mode == MODE_HOUR) n_mode = MODE_MINUTE;
                        else                          n_mode = MODE_CLOCK;
                    end
                    acc_pkg::KEY_ALARM: begin
                        if (r_mode == MODE_CLOCK) begin
                            n_alarm_hour = r_st_hour;
                            n_alarm_min  = r_st_min;
                            n_mode       = MODE_ALARM_HOUR;
                        end else if (r_mode == MODE_ALARM_HOUR) begin
                            n_mode = MODE_ALARM_MINUTE;
                        end else begin
                            n_mode = MODE_CLOCK;
                            if (r_alarm_changed) begin
                                n_st_hour       = r_alarm_hour;
                                n_st_min        = r_alarm_min;
                                n_alarm_changed = 1'b0;
                                saved           = 1'b1;
                            end
                        end
                    end
                    acc_pkg::KEY_UP, acc_pkg::KEY_DOWN: begin
                        case (r_mode)
                            MODE_HOUR: begin
                                n_hours = (r_a_key == acc_pkg::KEY_UP)
                                    ? acc_pkg::HOUR_W'(acc_pkg::wrap_up({1'b0, r_hours},
                                                                        acc_pkg::HOUR_MAX))
                                    : acc_pkg::HOUR_W'(acc_pkg::wrap_down({1'b0, r_hours},
                                                                          acc_pkg::HOUR_MAX));
                            end
                            MODE_MINUTE: begin
                                n_minutes = (r_a_key == acc_pkg::KEY_UP)
                                    ? acc_pkg::wrap_up(r_minutes, acc_pkg::MINUTE_MAX)
                                    : acc_pkg::wrap_down(r_minutes, acc_pkg::MINUTE_MAX);
                            end
                            MODE_ALARM_HOUR: begin
                                n_alarm_hour = (r_a_key == acc_pkg::KEY_UP)
                                    ? acc_pkg::HOUR_W'(acc_pkg::wrap_up({1'b0, r_alarm_hour},
                                                                        acc_pkg::HOUR_MAX))
                                    : acc_pkg::HOUR_W'(acc_pkg::wrap_down({1'b0, r_alarm_hour},
                                                                          acc_pkg::HOUR_MAX));
                                n_alarm_changed = 1'b1;
                            end
                            MODE_ALARM_MINUTE: begin
                                n_alarm_min = (r_a_key == acc_pkg::KEY_UP)
                                    ? acc_pkg::wrap_up(r_alarm_min, acc_pkg::MINUTE_MAX)
                                    : acc_pkg::wrap_down(r_alarm_min, acc_pkg::MINUTE_MAX);
                                n_alarm_changed = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                    default: begin
                    end
                endcase
            end
        end

        // time of day runs in normal mode only
        if (n_mode == MODE_CLOCK) begin
            n_subsec = acc_pkg::sat_inc(n_subsec);
            if (n_subsec >= r_cfg_tps) begin
                n_subsec     = '0;
                time_carry_m = (n_seconds >= acc_pkg::MINUTE_MAX);
                n_seconds    = acc_pkg::wrap_up(n_seconds, acc_pkg::MINUTE_MAX);
                if (time_carry_m) begin
                    time_carry_h = (n_minutes >= acc_pkg::MINUTE_MAX);
                    n_minutes    = acc_pkg::wrap_up(n_minutes, acc_pkg::MINUTE_MAX);
                    if (time_carry_h) begin
                        n_hours = acc_pkg::HOUR_W'(acc_pkg::wrap_up({1'b0, n_hours},
                                                                    acc_pkg::HOUR_MAX));
                    end
                end
            end
        end

        // alarm; the phase counter follows ring_count modulo the ring period
        if (!n_ringing && n_mode == MODE_CLOCK && n_hours == n_alarm_hour &&
            n_minutes == n_alarm_min && n_seconds == '0) begin
            n_ringing    = 1'b1;
            n_ring_count = '0;
            n_ring_phase = '0;
        end
        if (n_ringing) begin
            n_ring_count = acc_pkg::sat_inc(n_ring_count);
            n_ring_phase = (n_ring_phase == acc_pkg::RING_PH_W'(acc_pkg::RING_PERIOD - 1))
                ? '0 : n_ring_phase + 1'b1;
            n_buzzer = (n_ring_phase < acc_pkg::RING_PH_W'(acc_pkg::RING_ON_PART));
            if (n_ring_count >= r_cfg_ring) begin
                n_ringing = 1'b0;
                n_buzzer  = 1'b0;
            end
        end

        // beep countdown
        if (n_beep_count != '0) begin
            n_beep_count = n_beep_count - 1'b1;
            if (n_beep_count == '0 && !n_ringing) begin
                n_buzzer = 1'b0;
            end
        end

        // display sees the blink phase before this tick's toggle
        disp_req.alarm_view   = (n_mode == MODE_ALARM_HOUR) || (n_mode == MODE_ALARM_MINUTE);
        disp_req.blank_hour   = n_blink_phase &&
                                ((n_mode == MODE_HOUR) || (n_mode == MODE_ALARM_HOUR));
        disp_req.blank_minute = n_blink_phase &&
                                ((n_mode == MODE_MINUTE) || (n_mode == MODE_ALARM_MINUTE));
        disp_req.hour         = disp_req.alarm_view ? n_alarm_hour : n_hours;
        disp_req.minute       = disp_req.alarm_view ? n_alarm_min : n_minutes;

        // inactivity timeout
        if (n_mode != MODE_CLOCK) begin
            n_idle_count = acc_pkg::sat_inc(n_idle_count);
            if (n_idle_count >= r_cfg_idle) begin
                n_mode       = MODE_CLOCK;
                n_idle_count = '0;
                n_buzzer     = 1'b1;
                n_beep_count = r_cfg_beep;
            end
        end

        // blink
        n_blink_count = acc_pkg::sat_inc(n_blink_count);
        if (n_blink_count >= r_cfg_blink) begin
            n_blink_count = '0;
            n_blink_phase = !n_blink_phase;
        end

        led = ((n_mode == MODE_ALARM_HOUR) || (n_mode == MODE_ALARM_MINUTE)) && n_blink_phase;
    end

    acc_display u_display (
        .i_req  (disp_req),
        .o_disp (disp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tps   <= acc_pkg::RST_TICKS_PER_SEC;
            r_cfg_idle  <= acc_pkg::RST_INACTIVITY;
            r_cfg_ring  <= acc_pkg::RST_RING;
            r_cfg_beep  <= acc_pkg::RST_BEEP;
            r_cfg_blink <= acc_pkg::RST_BLINK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                acc_pkg::CFG_TICKS_PER_SEC: r_cfg_tps   <= i_cfg_data;
                acc_pkg::CFG_INACTIVITY:    r_cfg_idle  <= i_cfg_data;
                acc_pkg::CFG_RING:          r_cfg_ring  <= i_cfg_data;
                acc_pkg::CFG_BEEP:          r_cfg_beep  <= i_cfg_data;
                acc_pkg::CFG_BLINK:         r_cfg_blink <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_a_valid <= 1'b1;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_a_key <= i_in.key_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_CLOCK;
            r_hours         <= '0;
            r_minutes       <= '0;
            r_seconds       <= '0;
            r_subsec        <= '0;
            r_alarm_hour    <= acc_pkg::RST_ALARM_HOUR;
            r_alarm_min     <= acc_pkg::RST_ALARM_MIN;
            r_st_hour       <= acc_pkg::RST_ALARM_HOUR;
            r_st_min        <= acc_pkg::RST_ALARM_MIN;
            r_alarm_changed <= 1'b0;
            r_ringing       <= 1'b0;
            r_ring_count    <= '0;
            r_ring_phase    <= '0;
            r_beep_count    <= '0;
            r_idle_count    <= '0;
            r_blink_count   <= '0;
            r_blink_phase   <= 1'b0;
            r_buzzer        <= 1'b0;
        end else if (a_fire) begin
            r_mode          <= n_mode;
            r_hours         <= n_hours;
            r_minutes       <= n_minutes;
            r_seconds       <= n_seconds;
            r_subsec        <= n_subsec;
            r_alarm_hour    <= n_alarm_hour;
            r_alarm_min     <= n_alarm_min;
            r_st_hour       <= n_st_hour;
            r_st_min        <= n_st_min;
            r_alarm_changed <= n_alarm_changed;
            r_ringing       <= n_ringing;
            r_ring_count    <= n_ring_count;
            r_ring_phase    <= n_ring_phase;
            r_beep_count    <= n_beep_count;
            r_idle_count    <= n_idle_count;
            r_blink_count   <= n_blink_count;
            r_blink_phase   <= n_blink_phase;
            r_buzzer        <= n_buzzer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (a_fire) begin
            r_out_disp      <= disp;
            r_out_buzzer    <= n_buzzer;
            r_out_led       <= led;
            r_out_save      <= saved;
            r_out_save_hour <= saved ? n_st_hour : '0;
            r_out_save_min  <= saved ? n_st_min : '0;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.digit_hour_tens    = r_out_disp.hour_tens;
    assign o_out.digit_hour_units   = r_out_disp.hour_units;
    assign o_out.digit_minute_tens  = r_out_disp.minute_tens;
    assign o_out.digit_minute_units = r_out_disp.minute_units;
    assign o_out.buzzer_on          = r_out_buzzer;
    assign o_out.alarm_mode_led     = r_out_led;
    assign o_out.save_strobe        = r_out_save;
    assign o_out.save_hour          = r_out_save_hour;
    assign o_out.save_minute        = r_out_save_min;

endmodule

// ===== src/acc_checker.sv =====
// ---------------------------------------------------------------------------
// Alarm clock controller checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "alarm_clock_controller_unit_defines.svh"

module acc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [acc_pkg::SEG_W-1:0]  i_hour_units,
    input logic                       i_led,
    input logic                       i_save_strobe,
    input logic [acc_pkg::HOUR_W-1:0] i_save_hour,
    input logic [acc_pkg::MIN_W-1:0]  i_save_minute
);

    // result transaction held while stalled
    `ACC_ASSERT_NEXT(a_out_hold, i_rst_n && i_out_valid && !i_out_ready, i_out_valid)

    // no result straight after reset
    `ACC_ASSERT_NEXT(a_rst_clear, !i_rst_n, !i_out_valid)

    // a saved alarm is always a legal time
    `ACC_ASSERT_IMPL(a_save_range, i_out_valid && i_save_strobe, (i_save_hour <= 5'd23) && (i_save_minute <= 6'd59))

    // save fields are zero without a strobe
    `ACC_ASSERT_IMPL(a_save_zero, i_out_valid && !i_save_strobe, (i_save_hour == '0) && (i_save_minute == '0))

    // LED only in alarm view, where the colon is off
    `ACC_ASSERT_IMPL(a_led_colon, i_out_valid && i_led, !i_hour_units[7])

endmodule

bind alarm_clock_controller_unit acc_checker u_acc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_hour_units  (o_out.digit_hour_units),
    .i_led         (o_out.alarm_mode_led),
    .i_save_strobe (o_out.save_strobe),
    .i_save_hour   (o_out.save_hour),
    .i_save_minute (o_out.save_minute)
);
